FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

FILE: hdl/icy_pkg.sv
package icy_pkg;

	typedef enum logic [1:0] {
		PH_AUDIO = 2'd0,
		PH_LEN   = 2'd1,
		PH_META  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		TS_MATCH  = 2'd0,
		TS_ACTIVE = 2'd1,
		TS_IDLE   = 2'd2
	} tstate_t;

	typedef enum logic [1:0] {
		K_AUDIO = 2'd0,
		K_CHAR  = 2'd1,
		K_END   = 2'd2,
		K_ERR   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} res_t;

	localparam int          MI_W         = 20;
	localparam int          MMB_W        = 8;
	localparam int          ML_W         = 12;
	localparam int          PP_W         = 4;
	localparam logic [MI_W-1:0]  MI_RESET  = 20'd8192;
	localparam logic [MMB_W-1:0] MMB_RESET = 8'd32;

	localparam logic [PP_W-1:0] PREFIX_LEN = 4'd13;
	localparam logic [7:0]      CH_QUOTE   = 8'h27;
	localparam logic [7:0]      CH_SEMI    = 8'h3b;

	localparam logic REG_META_INTERVAL   = 1'b0;
	localparam logic REG_MAX_META_BLOCKS = 1'b1;

	localparam int Q_DEPTH = 8;
	localparam int Q_AW    = 3;
	localparam int Q_CW    = 4;

	// StreamTitle='
	function automatic logic [7:0] prefix_char(logic [PP_W-1:0] pos);
		logic [7:0] ch;
		case (pos)
			4'd0:    ch = 8'h53;
			4'd1:    ch = 8'h74;
			4'd2:    ch = 8'h72;
			4'd3:    ch = 8'h65;
			4'd4:    ch = 8'h61;
			4'd5:    ch = 8'h6d;
			4'd6:    ch = 8'h54;
			4'd7:    ch = 8'h69;
			4'd8:    ch = 8'h74;
			4'd9:    ch = 8'h6c;
			4'd10:   ch = 8'h65;
			4'd11:   ch = 8'h3d;
			4'd12:   ch = 8'h27;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

FILE: hdl/icy_in_if.sv
interface icy_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

FILE: hdl/icy_out_if.sv
interface icy_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_kind, output out_byte, output last_of_run,
		input ready);
	modport sink (input valid, input out_kind, input out_byte, input last_of_run,
		output ready);
endinterface

FILE: hdl/icy_metadata_demux.sv
// ICY metadata demultiplexer.
// stream (sink): one raw stream byte per transfer. result (source): results of
// kind audio, title character, title end or oversize error, in order; last_of_run
// marks the final result caused by one stream byte (a byte may cause none).
// APB port: register 0 meta_interval at 0x0, register 1 max_meta_blocks at 0x4;
// write only while the block is idle. Writing meta_interval restarts framing.
// Path: a byte is registered in the input register, parsed from there once the
// result queue has room, and its results are then written into the result queue.
// Throughput: one stream byte per cycle, limited by the result side, which
// delivers one result per cycle from an 8-entry result queue; a byte enters
// parsing only while at least three queue entries are free.
// Reset: meta_interval 8192, max_meta_blocks 32, audio phase, queue empty.
// A stalled receiver fills the queue, then the input register, then stream.ready
// drops; nothing is lost or repeated.
`include "assert_macros.svh"

module icy_metadata_demux #(
	parameter int TITLE_MAX = 39
) (
	input  logic        clk,
	input  logic        arst_n,
	icy_in_if.sink      stream,
	icy_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import icy_pkg::*;

	localparam int TCW = $clog2(TITLE_MAX + 1);

	typedef struct packed {
		res_t [2:0]     res;
		logic [1:0]     n;
		tstate_t        ts;
		logic           hq;
		logic [TCW-1:0] tc;
	} ctx_t;

	function automatic ctx_t f_push(ctx_t c, kind_t k, logic [7:0] d);
		if (c.n != 2'd3) begin
			c.res[c.n].kind = k;
			c.res[c.n].data = d;
			c.res[c.n].last = 1'b0;
			c.n = c.n + 2'd1;
		end
		return c;
	endfunction

	function automatic ctx_t f_end(ctx_t c);
		c = f_push(c, K_END, 8'h00);
		c.ts = TS_IDLE;
		c.hq = 1'b0;
		return c;
	endfunction

	function automatic ctx_t f_emit(ctx_t c, logic [7:0] ch);
		c = f_push(c, K_CHAR, ch);
		c.tc = c.tc + 1'b1;
		if (c.tc >= TCW'(TITLE_MAX)) begin
			c = f_end(c);
		end
		return c;
	endfunction

	function automatic ctx_t f_tbyte(ctx_t c, logic [7:0] b);
		if (b == 8'h00) begin
			c = f_end(c);
		end else if (b == CH_QUOTE) begin
			c.hq = 1'b1;
		end else begin
			c = f_emit(c, b);
		end
		return c;
	endfunction

	logic [MI_W-1:0]  mi_q;
	logic [MMB_W-1:0] mmb_q;
	phase_t           phase_q, phase_d;
	logic [MI_W-1:0]  al_q, al_d;
	logic [ML_W-1:0]  ml_q, ml_d;
	logic [PP_W-1:0]  pp_q, pp_d;
	tstate_t          ts_q;
	logic             hq_q;
	logic [TCW-1:0]   tc_q;
	ctx_t             c;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             adv;
	logic             in_xfer;
	logic             pop;
	logic             cfg_wr;

	res_t             fifo_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_q;
	logic [Q_AW-1:0]  rd_q;
	logic [Q_CW-1:0]  count_q;
	logic [Q_CW-1:0]  n_push;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_META_INTERVAL:   prdata = {{(32 - MI_W){1'b0}}, mi_q};
			REG_MAX_META_BLOCKS: prdata = {{(32 - MMB_W){1'b0}}, mmb_q};
			default:             prdata = '0;
		endcase
	end

	assign adv          = valid_s1 && (count_q <= Q_CW'(Q_DEPTH - 3));
	assign stream.ready = !valid_s1 || adv;
	assign in_xfer      = stream.valid && stream.ready;
	assign pop          = result.valid && result.ready;
	assign n_push       = adv ? Q_CW'(c.n) : '0;

	always_comb begin
		c       = '0;
		c.ts    = ts_q;
		c.hq    = hq_q;
		c.tc    = tc_q;
		phase_d = phase_q;
		al_d    = al_q;
		ml_d    = ml_q;
		pp_d    = pp_q;

		if (mi_q == '0 || phase_q == PH_AUDIO) begin
			c = f_push(c, K_AUDIO, byte_s1);
			if (mi_q != '0) begin
				if (al_q <= MI_W'(1)) begin
					phase_d = PH_LEN;
					al_d    = mi_q;
				end else begin
					al_d = al_q - 1'b1;
				end
			end
		end else if (phase_q == PH_LEN) begin
			if (byte_s1 == 8'h00) begin
				phase_d = PH_AUDIO;
				al_d    = mi_q;
			end else if (byte_s1 > mmb_q) begin
				c       = f_push(c, K_ERR, 8'h00);
				phase_d = PH_AUDIO;
				al_d    = mi_q;
			end else begin
				phase_d = PH_META;
				ml_d    = {byte_s1, 4'b0000};
				pp_d    = '0;
				c.ts    = TS_MATCH;
				c.hq    = 1'b0;
				c.tc    = '0;
			end
		end else begin
			if (c.ts == TS_MATCH) begin
				if (pp_q < PREFIX_LEN && byte_s1 == prefix_char(pp_q)) begin
					pp_d = pp_q + 1'b1;
					if (pp_d >= PREFIX_LEN) begin
						c.ts = TS_ACTIVE;
					end
				end else begin
					c.ts = TS_IDLE;
				end
			end else if (c.ts == TS_ACTIVE) begin
				if (c.hq) begin
					c.hq = 1'b0;
					if (byte_s1 == CH_SEMI) begin
						c = f_end(c);
					end else begin
						c = f_emit(c, CH_QUOTE);
						if (c.ts == TS_ACTIVE) begin
							c = f_tbyte(c, byte_s1);
						end
					end
				end else begin
					c = f_tbyte(c, byte_s1);
				end
			end
			if (ml_q != '0) begin
				ml_d = ml_q - 1'b1;
			end
			if (ml_d == '0) begin
				if (c.ts == TS_ACTIVE) begin
					if (c.hq) begin
						c.hq = 1'b0;
						c = f_emit(c, CH_QUOTE);
					end
					if (c.ts == TS_ACTIVE) begin
						c = f_end(c);
					end
				end
				phase_d = PH_AUDIO;
				al_d    = mi_q;
				c.ts    = TS_IDLE;
				c.hq    = 1'b0;
			end
		end

		if (c.n != 2'd0) begin
			c.res[c.n - 2'd1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mi_q    <= MI_RESET;
			mmb_q   <= MMB_RESET;
			phase_q <= PH_AUDIO;
			al_q    <= MI_RESET;
			ml_q    <= '0;
			pp_q    <= '0;
			ts_q    <= TS_MATCH;
			hq_q    <= 1'b0;
			tc_q    <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_META_INTERVAL) begin
				mi_q    <= pwdata[MI_W-1:0];
				phase_q <= PH_AUDIO;
				al_q    <= pwdata[MI_W-1:0];
				ml_q    <= '0;
				pp_q    <= '0;
				ts_q    <= TS_MATCH;
				hq_q    <= 1'b0;
				tc_q    <= '0;
			end else begin
				mmb_q <= pwdata[MMB_W-1:0];
			end
		end else if (adv) begin
			phase_q <= phase_d;
			al_q    <= al_d;
			ml_q    <= ml_d;
			pp_q    <= pp_d;
			ts_q    <= c.ts;
			hq_q    <= c.hq;
			tc_q    <= c.tc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= stream.stream_byte;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (adv && 2'(i) < c.n) begin
				fifo_q[wr_q + Q_AW'(i)] <= c.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[Q_AW-1:0];
			rd_q    <= rd_q + Q_AW'(pop);
			count_q <= count_q + n_push - Q_CW'(pop);
		end
	end

	assign result.valid       = (count_q != '0);
	assign result.out_kind    = fifo_q[rd_q].kind;
	assign result.out_byte    = fifo_q[rd_q].data;
	assign result.last_of_run = fifo_q[rd_q].last;

	`ASSERT_IMPL(a_queue_bound, clk, arst_n, 1'b1, count_q <= Q_CW'(Q_DEPTH))
	`ASSERT_IMPL(a_title_bound, clk, arst_n, 1'b1, tc_q <= TCW'(TITLE_MAX))
	`ASSERT_IMPL(a_quote_in_title, clk, arst_n, hq_q, phase_q == PH_META && ts_q == TS_ACTIVE)
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, valid_s1 && !adv && !cfg_wr, valid_s1 && $stable(byte_s1))

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import icy_pkg::*;

	localparam int TITLE_LIMIT = 39;
	localparam int IDLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PRINT_LIMIT = 40;
	localparam logic [8*13-1:0] TITLE_TAG = "StreamTitle='";

	typedef enum {RX_STREAM, RX_RANDOM, RX_PERIODIC} rx_mode_t;
	typedef enum {
		BODY_SEMI_END, BODY_ZERO_END, BODY_QUOTE_AT_END, BODY_LONG_TITLE,
		BODY_BAD_TAG, BODY_ZERO_IN_TAG, BODY_NOISE, BODY_QUOTE_MIX
	} body_kind_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	icy_in_if  stream_if();
	icy_out_if result_if();

	icy_metadata_demux #(.TITLE_MAX(TITLE_LIMIT)) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream_if),
		.result  (result_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// demux predictor state
	logic [19:0] mi_cfg;
	logic [7:0]  mmb_cfg;
	phase_t      cur_phase;
	logic [19:0] audio_cnt;
	logic [11:0] meta_cnt;
	logic [3:0]  tag_pos;
	tstate_t     title_st;
	logic        quote_held;
	logic [5:0]  title_len;

	res_t pending_results[$];
	res_t byte_results[$];
	res_t want;

	int mismatches = 0;
	int cycle_count = 0;
	int bytes_sent = 0;
	int burst_left = 0;

	rx_mode_t rx_mode = RX_STREAM;
	int rx_left = 0;
	int rx_period = 2;
	int rx_tick = 0;

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic logic [7:0] tag_byte(input logic [3:0] pos);
		return TITLE_TAG[8*(12-pos) +: 8];
	endfunction

	task automatic add_result(input kind_t k, input logic [7:0] d);
		res_t r;
		r.kind = k;
		r.data = d;
		r.last = 1'b0;
		if (byte_results.size() < 3)
			byte_results.push_back(r);
	endtask

	task automatic close_title();
		add_result(K_END, 8'd0);
		title_st = TS_IDLE;
		quote_held = 1'b0;
	endtask

	task automatic title_char(input logic [7:0] c);
		add_result(K_CHAR, c);
		title_len = title_len + 6'd1;
		if (title_len >= TITLE_LIMIT)
			close_title();
	endtask

	task automatic title_input(input logic [7:0] b);
		if (b == 8'd0)
			close_title();
		else if (b == CH_QUOTE)
			quote_held = 1'b1;
		else
			title_char(b);
	endtask

	task automatic reframe();
		cur_phase = PH_AUDIO;
		audio_cnt = mi_cfg;
		meta_cnt = '0;
		tag_pos = '0;
		title_st = TS_MATCH;
		quote_held = 1'b0;
		title_len = '0;
	endtask

	task automatic apply_register(input logic idx, input logic [31:0] value);
		if (idx == REG_META_INTERVAL) begin
			mi_cfg = value[19:0];
			reframe();
		end else begin
			mmb_cfg = value[7:0];
		end
	endtask

	task automatic predict_stream_byte(input logic [7:0] b);
		res_t r;
		byte_results.delete();
		if (mi_cfg == '0 || cur_phase == PH_AUDIO) begin
			add_result(K_AUDIO, b);
			if (mi_cfg != '0) begin
				if (audio_cnt <= 20'd1) begin
					cur_phase = PH_LEN;
					audio_cnt = mi_cfg;
				end else begin
					audio_cnt = audio_cnt - 20'd1;
				end
			end
		end else if (cur_phase == PH_LEN) begin
			if (b == 8'd0) begin
				cur_phase = PH_AUDIO;
				audio_cnt = mi_cfg;
			end else if (b > mmb_cfg) begin
				add_result(K_ERR, 8'd0);
				cur_phase = PH_AUDIO;
				audio_cnt = mi_cfg;
			end else begin
				cur_phase = PH_META;
				meta_cnt = {b, 4'h0};
				tag_pos = '0;
				title_st = TS_MATCH;
				quote_held = 1'b0;
				title_len = '0;
			end
		end else begin
			case (title_st)
				TS_MATCH: begin
					if (tag_pos < PREFIX_LEN && b == tag_byte(tag_pos)) begin
						tag_pos = tag_pos + 4'd1;
						if (tag_pos >= PREFIX_LEN)
							title_st = TS_ACTIVE;
					end else begin
						title_st = TS_IDLE;
					end
				end
				TS_ACTIVE: begin
					if (quote_held) begin
						quote_held = 1'b0;
						if (b == CH_SEMI) begin
							close_title();
						end else begin
							title_char(CH_QUOTE);
							if (title_st == TS_ACTIVE)
								title_input(b);
						end
					end else begin
						title_input(b);
					end
				end
				default: ;
			endcase
			if (meta_cnt != '0)
				meta_cnt = meta_cnt - 12'd1;
			if (meta_cnt == '0) begin
				if (title_st == TS_ACTIVE) begin
					if (quote_held) begin
						quote_held = 1'b0;
						title_char(CH_QUOTE);
					end
					if (title_st == TS_ACTIVE)
						close_title();
				end
				cur_phase = PH_AUDIO;
				audio_cnt = mi_cfg;
				title_st = TS_IDLE;
				quote_held = 1'b0;
			end
		end
		if (byte_results.size() > 0) begin
			r = byte_results.pop_back();
			r.last = 1'b1;
			byte_results.push_back(r);
		end
		foreach (byte_results[i])
			pending_results.push_back(byte_results[i]);
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				@(negedge clk);
				stream_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		stream_if.valid <= 1'b1;
		stream_if.stream_byte <= b;
		do @(posedge clk); while (!stream_if.ready);
		predict_stream_byte(b);
		bytes_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		stream_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_register(input logic idx, input logic [31:0] expected);
		logic [31:0] rd;
		apb_access(1'b0, {idx, 2'b00}, 32'd0, rd);
		if (rd !== expected)
			report_mismatch($sformatf("register %0d read %08h, want %08h", idx, rd, expected));
	endtask

	task automatic set_framing(input logic [19:0] interval, input logic [7:0] blocks);
		logic [31:0] rd;
		settle();
		apb_access(1'b1, {REG_META_INTERVAL, 2'b00}, {12'd0, interval}, rd);
		apply_register(REG_META_INTERVAL, {12'd0, interval});
		apb_access(1'b1, {REG_MAX_META_BLOCKS, 2'b00}, {24'd0, blocks}, rd);
		apply_register(REG_MAX_META_BLOCKS, {24'd0, blocks});
		check_register(REG_META_INTERVAL, {12'd0, mi_cfg});
		check_register(REG_MAX_META_BLOCKS, {24'd0, mmb_cfg});
	endtask

	function automatic logic [7:0] rand_letter();
		return 8'($urandom_range(8'h41, 8'h7a));
	endfunction

	function automatic logic [7:0] rand_title_char();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 14)
			return 8'($urandom_range(32, 126));
		else if (pick < 17)
			return CH_QUOTE;
		else if (pick < 19)
			return CH_SEMI;
		return 8'($urandom);
	endfunction

	task automatic send_tag();
		for (int i = 0; i < PREFIX_LEN; i++)
			send_byte(tag_byte(4'(i)));
	endtask

	task automatic send_meta(input int n);
		logic [7:0] body[$];
		body_kind_t how;
		how = body_kind_t'($urandom_range(0, 7));
		if (how != BODY_NOISE)
			for (int i = 0; i < PREFIX_LEN; i++)
				body.push_back(tag_byte(4'(i)));
		case (how)
			BODY_SEMI_END, BODY_ZERO_END: begin
				repeat ($urandom_range(0, n - 15)) body.push_back(rand_letter());
				if (how == BODY_SEMI_END) begin
					body.push_back(CH_QUOTE);
					body.push_back(CH_SEMI);
				end else begin
					body.push_back(8'h00);
				end
			end
			BODY_QUOTE_AT_END: begin
				while (body.size() < n - 1) body.push_back(rand_letter());
				body.push_back(CH_QUOTE);
			end
			BODY_LONG_TITLE: begin
				while (body.size() < n) body.push_back(rand_letter());
			end
			BODY_BAD_TAG: body[$urandom_range(0, 12)] = 8'($urandom);
			BODY_ZERO_IN_TAG: body[$urandom_range(0, 12)] = 8'h00;
			default: ;
		endcase
		while (body.size() < n)
			body.push_back((how == BODY_NOISE) ? 8'($urandom) : rand_title_char());
		while (body.size() > n)
			void'(body.pop_back());
		foreach (body[k])
			send_byte(body[k]);
	endtask

	task automatic test_reset_defaults();
		check_register(REG_META_INTERVAL, {12'd0, MI_RESET});
		check_register(REG_MAX_META_BLOCKS, {24'd0, MMB_RESET});
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// zero length, oversize, held quote followed by a plain byte at the block end
	task automatic test_special_cases();
		set_framing(20'd1, 8'd2);
		send_byte(8'h00);
		send_byte(8'd0);
		send_byte(8'hFF);
		send_byte(8'd3);
		send_byte(8'h80);
		send_byte(8'd1);
		send_tag();
		send_byte("x");
		send_byte(CH_QUOTE);
		send_byte("y");
	endtask

	task automatic test_restart();
		set_framing(20'd3, 8'd2);
		send_byte(8'h5A);
		send_byte(8'hA5);
		set_framing(20'd2, 8'd2);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'd3);
		send_byte(8'h7F);
	endtask

	task automatic test_interval_zero();
		set_framing(20'd0, 8'($urandom_range(1, 255)));
		send_byte(8'h00);
		send_byte(8'hFF);
		repeat (10) send_byte(8'($urandom));
	endtask

	task automatic test_interval_max();
		set_framing(20'hFFFFF, 8'hFF);
		repeat (6) send_byte(8'($urandom));
	endtask

	task automatic test_long_title();
		set_framing(20'd1, 8'hFF);
		send_byte(8'($urandom));
		send_byte(8'd4);
		send_tag();
		repeat (4 * 16 - PREFIX_LEN) send_byte(rand_letter());
		send_byte(8'($urandom));
	endtask

	task automatic test_random_frames(input logic [19:0] interval, input logic [7:0] blocks,
		input int budget);
		int start;
		int pick;
		int len;
		set_framing(interval, blocks);
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			repeat (mi_cfg) send_byte(8'($urandom));
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				len = 0;
			end else if (pick == 1) begin
				len = $urandom_range(0, 255);
				if (len > 4 && len <= mmb_cfg)
					len = 1 + len % 4;
			end else if ((pick == 2 || mmb_cfg == 8'd0) && mmb_cfg != 8'hFF) begin
				len = $urandom_range(mmb_cfg + 1, 255);
			end else begin
				len = $urandom_range(1, (mmb_cfg < 8'd4) ? mmb_cfg : 4);
			end
			send_byte(8'(len));
			if (len != 0 && len <= mmb_cfg)
				send_meta(len * 16);
		end
	endtask

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_period = $urandom_range(2, 4);
			rx_left = $urandom_range(16, 96);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_STREAM:   result_if.ready <= 1'b1;
			RX_RANDOM:   result_if.ready <= ($urandom_range(0, 1) == 1);
			RX_PERIODIC: result_if.ready <= (rx_tick % rx_period == 0);
			default:     result_if.ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d byte %02h",
					result_if.out_kind, result_if.out_byte));
			end else begin
				want = pending_results.pop_front();
				if (result_if.out_kind !== want.kind)
					report_mismatch($sformatf("out_kind %0d, want %0d",
						result_if.out_kind, want.kind));
				if (result_if.out_byte !== want.data)
					report_mismatch($sformatf("out_byte %02h, want %02h",
						result_if.out_byte, want.data));
				if (result_if.last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run %0b, want %0b",
						result_if.last_of_run, want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stream_if.valid = 1'b0;
		stream_if.stream_byte = '0;
		mi_cfg = MI_RESET;
		mmb_cfg = MMB_RESET;
		reframe();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_special_cases();
		test_restart();
		test_interval_zero();
		test_interval_max();
		test_long_title();
		test_random_frames(20'd1, 8'd1, 10);
		test_random_frames(20'd3, 8'hFF, 10);
		test_random_frames(20'd2, 8'd0, 5);
		test_random_frames(20'($urandom_range(1, 12)), 8'($urandom_range(1, 6)), 10);
		test_random_frames(20'($urandom_range(1, 12)), 8'($urandom_range(1, 6)), 10);

		settle();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
